// ===== rtl/gs7_pkg.sv =====
// shared constants, types and kernel arithmetic of the 7x7 gaussian smoother
package gs7_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int ROW_W         = 10;
    localparam int CFG_W         = 11;
    localparam int CFG_AW        = 2;
    localparam int PIX_W         = 8;
    localparam int OUT_POS_W     = 10;
    localparam int OUT_DATA_W    = 32;
    localparam int PAD_W         = OUT_DATA_W - PIX_W - 2 * OUT_POS_W;
    localparam int HS_W          = 14;
    localparam int VS_W          = 20;
    localparam int STORE_ROWS    = 6;
    localparam int SLOT_W        = 3;
    localparam int KERN_TAPS     = 7;
    localparam int KERN_HALF     = 3;
    localparam int MIN_SIZE      = 8;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int ROUND_BIAS    = 2048;
    localparam int ROUND_SHIFT   = 12;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = CFG_AW'(1);

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [HS_W-1:0]   t_hsum;
    typedef logic [VS_W-1:0]   t_vsum;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [SLOT_W-1:0] t_slot;

    // control that travels with one request down the pipeline
    typedef struct packed {
        logic  vld;
        logic  wr;
        logic  emit;
        t_slot slot;
        t_row  y0;
        t_row  y1;
    } t_ctl;

    // centre part of the kernel: 2*(9*a3 + 7*(a2+a4))
    function automatic t_vsum kern_mid(input t_hsum a2, input t_hsum a3, input t_hsum a4);
        t_vsum x3;
        t_vsum s;
        x3 = VS_W'(a3);
        s  = VS_W'(a2) + VS_W'(a4);
        return ((x3 << 3) + x3 + (s << 3) - s) << 1;
    endfunction

    // outer part of the kernel: 2*(a0+a6) + 7*(a1+a5)
    function automatic t_vsum kern_out(input t_hsum a0, input t_hsum a1, input t_hsum a5,
                                       input t_hsum a6);
        t_vsum e;
        t_vsum s;
        e = VS_W'(a0) + VS_W'(a6);
        s = VS_W'(a1) + VS_W'(a5);
        return (e << 1) + (s << 3) - s;
    endfunction

endpackage

// ===== rtl/gaussian_7x7_fixed_smoother.sv =====
// top level of the 7x7 separable gaussian smoother for 8-bit pixel streams
// Takes one 8-bit pixel per clock in raster order while s_axis_tready is high and
// returns smoothed pixels with their row and column, passing through the row
// window, line-store read, kernel register and output register. An interior pixel
// gives one copy; a pixel on a border row or column turns into a block of up to
// 4x4 copies (16 at a corner), and the input is held off while the output
// register replays it. While the pipeline advances, one 84-bit column entry of
// the MAX_WIDTH-deep store is read and at most one 14-bit lane written per cycle.
// tlast marks the last copy caused by an input pixel. Writing either size
// register (clamped to 8..MAX_WIDTH and 8..1024) restarts the frame at row 0,
// column 0; write only while idle. The line store needs no clearing after reset,
// since a row is written before read.
module gaussian_7x7_fixed_smoother
    import gs7_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel_in [7:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out [7:0], out_row [17:8], out_col [27:18], zero [31:28]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // run_last
);

    localparam int CW            = $clog2(MAX_WIDTH);
    localparam int WW            = $clog2(MAX_WIDTH + 1);
    localparam int CMPW          = (WW > CFG_W) ? WW : CFG_W;
    localparam int RESET_W_CLAMP = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WW-1:0]    r_w;
    logic [CFG_W-1:0] r_h;
    logic [CW-1:0]    r_col;
    t_row             r_row;
    t_slot            r_slot;
    t_ctl             r_s1;
    logic [CW-1:0]    r_s1_x;
    logic [CW-1:0]    r_s1_x0;
    logic [CW-1:0]    r_s1_x1;

    logic [WW-1:0]    n_w;
    logic [CFG_W-1:0] n_h;
    t_ctl             n_s1;
    logic [CW-1:0]    n_x0;
    logic [CW-1:0]    n_x1;

    logic [CMPW-1:0]  w_wd_ext;
    logic             w_acc;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_wr;
    logic             w_emit;
    logic [CW-1:0]    w_x;
    t_row             w_y;
    t_hsum            w_hsum;
    t_ctl             w_s3;
    logic [CW-1:0]    w_s3_x0;
    logic [CW-1:0]    w_s3_x1;
    t_pix             w_s3_pix;
    logic             w_free;
    logic             w_load;

    // size clamping
    assign w_wd_ext = CMPW'(i_cfg_wdata);

    always_comb begin
        if (w_wd_ext < CMPW'(MIN_SIZE)) begin
            n_w = WW'(MIN_SIZE);
        end else if (w_wd_ext > CMPW'(MAX_WIDTH)) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(w_wd_ext);
        end
        if (i_cfg_wdata < CFG_W'(MIN_SIZE)) begin
            n_h = CFG_W'(MIN_SIZE);
        end else if (i_cfg_wdata > CFG_W'(MAX_HEIGHT)) begin
            n_h = CFG_W'(MAX_HEIGHT);
        end else begin
            n_h = i_cfg_wdata;
        end
    end

    // whole pipeline holds while a waiting block cannot enter the burst stage
    assign s_axis_tready = !(w_s3.vld && w_s3.emit) || w_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_s3.vld && w_s3.emit && s_axis_tready;

    assign w_col_last = (WW'(r_col) + WW'(1)) == r_w;
    assign w_row_last = (CFG_W'(r_row) + CFG_W'(1)) == r_h;
    assign w_wr       = r_col >= CW'(KERN_TAPS - 1);
    assign w_emit     = w_wr && (r_row >= ROW_W'(KERN_TAPS - 1));
    assign w_x        = r_col - CW'(KERN_HALF);
    assign w_y        = r_row - ROW_W'(KERN_HALF);

    // border copies widen the block to the frame edge
    always_comb begin
        n_x0 = (w_x == CW'(KERN_HALF)) ? '0 : w_x;
        n_x1 = (WW'(w_x) == r_w - WW'(KERN_HALF + 1)) ? CW'(r_w - WW'(1)) : w_x;
        n_s1.vld  = w_acc;
        n_s1.wr   = w_wr;
        n_s1.emit = w_emit;
        n_s1.slot = r_slot;
        n_s1.y0   = (w_y == ROW_W'(KERN_HALF)) ? '0 : w_y;
        n_s1.y1   = (CFG_W'(w_y) == r_h - CFG_W'(KERN_HALF + 1)) ?
                    ROW_W'(r_h - CFG_W'(1)) : w_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WW'(RESET_W_CLAMP);
            r_h    <= CFG_W'(RESET_HEIGHT);
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_s1   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_s1 <= n_s1;
            end
            if (i_cfg_we && (i_cfg_addr == REG_FRAME_WIDTH ||
                             i_cfg_addr == REG_FRAME_HEIGHT)) begin
                unique case (i_cfg_addr)
                    REG_FRAME_WIDTH:  r_w <= n_w;
                    REG_FRAME_HEIGHT: r_h <= n_h;
                    default: ;
                endcase
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end else if (w_acc) begin
                if (w_col_last) begin
                    r_col <= '0;
                    if (w_row_last) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_slot <= (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 :
                                  r_slot + SLOT_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_s1_x  <= w_x;
            r_s1_x0 <= n_x0;
            r_s1_x1 <= n_x1;
        end
    end

    gs7_hwin u_hwin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_acc),
        .i_pix   (s_axis_tdata),
        .o_hsum  (w_hsum)
    );

    gs7_vstore #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s_axis_tready),
        .i_s1    (r_s1),
        .i_s1_x  (r_s1_x),
        .i_s1_x0 (r_s1_x0),
        .i_s1_x1 (r_s1_x1),
        .i_hsum  (w_hsum),
        .o_s3    (w_s3),
        .o_x0    (w_s3_x0),
        .o_x1    (w_s3_x1),
        .o_pix   (w_s3_pix)
    );

    gs7_burst #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_pix         (w_s3_pix),
        .i_y0          (w_s3.y0),
        .i_y1          (w_s3.y1),
        .i_x0          (w_s3_x0),
        .i_x1          (w_s3_x1),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_col) < r_w) && (r_slot < SLOT_W'(STORE_ROWS)))
        else $error("input position outside the frame");

    a_stall_only_on_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !(m_axis_tready && m_axis_tlast)))
        else $error("input held off with no burst pending");

endmodule

// ===== rtl/gs7_hwin.sv =====
// seven-pixel row window and horizontal kernel sum
module gs7_hwin
    import gs7_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_pix  i_pix,
    output t_hsum o_hsum
);

    t_pix  r_win [KERN_TAPS];
    t_vsum w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERN_TAPS; i++) r_win[i] <= '0;
        end else if (i_shift) begin
            for (int i = 0; i < KERN_TAPS - 1; i++) r_win[i] <= r_win[i + 1];
            r_win[KERN_TAPS-1] <= i_pix;
        end
    end

    assign w_sum = kern_mid(HS_W'(r_win[2]), HS_W'(r_win[3]), HS_W'(r_win[4]))
                 + kern_out(HS_W'(r_win[0]), HS_W'(r_win[1]), HS_W'(r_win[5]),
                            HS_W'(r_win[6]));

    // the full kernel on 8-bit pixels stays below 2^14
    assign o_hsum = w_sum[HS_W-1:0];

endmodule

// ===== rtl/gs7_vstore.sv =====
// six-row line store of horizontal sums and the vertical kernel with rounding
module gs7_vstore
    import gs7_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  t_ctl          i_s1,
    input  logic [CW-1:0] i_s1_x,
    input  logic [CW-1:0] i_s1_x0,
    input  logic [CW-1:0] i_s1_x1,
    input  t_hsum         i_hsum,
    output t_ctl          o_s3,
    output logic [CW-1:0] o_x0,
    output logic [CW-1:0] o_x1,
    output t_pix          o_pix
);

    // one entry per column, one lane per stored row
    logic [STORE_ROWS-1:0][HS_W-1:0] r_mem [MAX_WIDTH];
    logic [STORE_ROWS-1:0][HS_W-1:0] r_rd;

    t_ctl          r_s2;
    t_ctl          r_s3;
    t_hsum         r_s2_hs;
    logic [CW-1:0] r_s2_x0;
    logic [CW-1:0] r_s2_x1;
    logic [CW-1:0] r_s3_x0;
    logic [CW-1:0] r_s3_x1;
    t_vsum         r_s3_mid;
    t_vsum         r_s3_out;
    t_hsum         w_tap [STORE_ROWS];
    t_vsum         w_sum;

    function automatic t_slot slot_at(input t_slot s, input int k);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + (SLOT_W + 1)'(k);
        if (t >= (SLOT_W + 1)'(STORE_ROWS)) t = t - (SLOT_W + 1)'(STORE_ROWS);
        return t[SLOT_W-1:0];
    endfunction

    // lane write of the current row and read of the whole column at once;
    // a read of the entry being written returns the old rows, which is wanted
    always_ff @(posedge i_clk) begin
        if (i_adv && i_s1.vld && i_s1.wr) begin
            r_mem[i_s1_x][i_s1.slot] <= i_hsum;
        end
        if (i_adv) begin
            r_rd <= r_mem[i_s1_x];
        end
    end

    // oldest row sits in the lane of the current slot
    always_comb begin
        for (int k = 0; k < STORE_ROWS; k++) begin
            w_tap[k] = r_rd[slot_at(r_s2.slot, k)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (i_adv) begin
            r_s2 <= i_s1;
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_hs  <= i_hsum;
            r_s2_x0  <= i_s1_x0;
            r_s2_x1  <= i_s1_x1;
            r_s3_x0  <= r_s2_x0;
            r_s3_x1  <= r_s2_x1;
            r_s3_mid <= kern_mid(w_tap[2], w_tap[3], w_tap[4]);
            r_s3_out <= kern_out(w_tap[0], w_tap[1], w_tap[5], r_s2_hs);
        end
    end

    assign w_sum = r_s3_mid + r_s3_out + VS_W'(ROUND_BIAS);
    assign o_pix = w_sum[ROUND_SHIFT +: PIX_W];
    assign o_s3  = r_s3;
    assign o_x0  = r_s3_x0;
    assign o_x1  = r_s3_x1;

endmodule

// ===== rtl/gs7_burst.sv =====
// output register that replays one smoothed pixel over its border block
module gs7_burst
    import gs7_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_pix                  i_pix,
    input  t_row                  i_y0,
    input  t_row                  i_y1,
    input  logic [CW-1:0]         i_x0,
    input  logic [CW-1:0]         i_x1,
    output logic                  o_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out [7:0], out_row [17:8], out_col [27:18], zero [31:28]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // run_last
);

    logic          r_busy;
    t_pix          r_pix;
    t_row          r_y;
    t_row          r_y1;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_x0;
    logic [CW-1:0] r_x1;
    logic          w_last;

    assign w_last = (r_y == r_y1) && (r_x == r_x1);
    assign o_free = !r_busy || (m_axis_tready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (m_axis_tready && w_last) begin
            r_busy <= 1'b0;
        end
    end

    // rows ascending, columns ascending within a row
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= i_pix;
            r_y   <= i_y0;
            r_y1  <= i_y1;
            r_x   <= i_x0;
            r_x0  <= i_x0;
            r_x1  <= i_x1;
        end else if (r_busy && m_axis_tready) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + ROW_W'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {PAD_W'(0), OUT_POS_W'(r_x), OUT_POS_W'(r_y), r_pix};

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("burst ended before its last result");

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_y <= r_y1) && (r_x <= r_x1)))
        else $error("burst position ran past its block");

endmodule

// ===== dv/tb_gaussian_7x7_fixed_smoother.sv =====
// self-checking stream testbench for the 7x7 gaussian smoother with its own pixel predictor
module tb_gaussian_7x7_fixed_smoother;
    import gs7_pkg::*;

    localparam int RANDOM_ITEMS   = 40;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [CFG_AW-1:0] REG_SPARE_A = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_SPARE_B = CFG_AW'(3);

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} t_flow;
    typedef enum {PAT_RANDOM, PAT_FLAT_HIGH, PAT_FLAT_LOW, PAT_CHECKER, PAT_GRADIENT,
                  PAT_EXTREME} t_pattern;

    typedef struct packed {
        t_pix                 pix;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 last;
    } t_smoothed;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;   // pixel_in [7:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // pixel_out [7:0], out_row [17:8], out_col [27:18]
    logic                  m_axis_tlast;         // run_last

    gaussian_7x7_fixed_smoother u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [CFG_W-1:0] cfg_width  = CFG_W'(RESET_WIDTH);
    logic [CFG_W-1:0] cfg_height = CFG_W'(RESET_HEIGHT);
    t_pix             row_window [0:KERN_TAPS-1];
    t_hsum            hsum_rows  [0:STORE_ROWS*MAX_WIDTH_DEF-1];
    int               cur_row = 0;
    int               cur_col = 0;

    t_smoothed smoothed_q[$];
    t_pix      pixel_queue[$];
    t_smoothed want;

    int pixels_queued   = 0;
    int pixels_taken    = 0;
    int predicted_total = 0;
    int fail_count      = 0;
    int stall_cycles    = 0;
    int idle_pct        = 0;
    int stall_pct       = 0;
    int hold_asked      = 0;
    int hold_done       = 0;
    int hold_left       = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < KERN_TAPS; i++) row_window[i] = '0;
    end

    function automatic int clamp_size(input int v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int gauss7(input int a0, input int a1, input int a2, input int a3,
                                  input int a4, input int a5, input int a6);
        return 2 * (a0 + a6) + 7 * (a1 + a5) + 14 * (a2 + a4) + 18 * a3;
    endfunction

    // advance the predictor by one pixel and queue the smoothed pixels it completes
    task automatic smooth_pixel(input t_pix p);
        int        w, h, x, y, hs, vsum, pix, r0, r1, c0, c1, lane;
        int        taps [0:KERN_TAPS-1];
        t_smoothed res;
        w = clamp_size(int'(cfg_width), MAX_WIDTH_DEF);
        h = clamp_size(int'(cfg_height), MAX_HEIGHT);
        for (int k = 0; k < KERN_TAPS - 1; k++) row_window[k] = row_window[k+1];
        row_window[KERN_TAPS-1] = p;
        if (cur_col >= KERN_TAPS - 1 && cur_col < w) begin
            x    = cur_col - KERN_HALF;
            lane = x % MAX_WIDTH_DEF;
            hs   = gauss7(row_window[0], row_window[1], row_window[2], row_window[3],
                          row_window[4], row_window[5], row_window[6]) & ((1 << HS_W) - 1);
            // slots (row + k) mod 6 hold rows row-6 .. row-1
            for (int k = 0; k < STORE_ROWS; k++)
                taps[k] = hsum_rows[((cur_row + k) % STORE_ROWS) * MAX_WIDTH_DEF + lane];
            taps[KERN_TAPS-1] = hs;
            hsum_rows[(cur_row % STORE_ROWS) * MAX_WIDTH_DEF + lane] = HS_W'(hs);
            if (cur_row >= KERN_TAPS - 1 && cur_row < h) begin
                y    = cur_row - KERN_HALF;
                vsum = gauss7(taps[0], taps[1], taps[2], taps[3], taps[4], taps[5], taps[6]);
                pix  = ((vsum + ROUND_BIAS) >> ROUND_SHIFT) & 8'hFF;
                // border rows and columns copy the nearest computed pixel
                r0 = (y == KERN_HALF) ? 0 : y;
                r1 = (y == h - KERN_HALF - 1) ? h - 1 : y;
                c0 = (x == KERN_HALF) ? 0 : x;
                c1 = (x == w - KERN_HALF - 1) ? w - 1 : x;
                for (int yy = r0; yy <= r1; yy++) begin
                    for (int xx = c0; xx <= c1; xx++) begin
                        res.pix  = PIX_W'(pix);
                        res.row  = OUT_POS_W'(yy);
                        res.col  = OUT_POS_W'(xx);
                        res.last = (yy == r1) && (xx == c1);
                        smoothed_q.push_back(res);
                        predicted_total++;
                    end
                end
            end
        end
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with an optional long hold-off once results start
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_asked != hold_done && m_axis_tvalid) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= hold_done + 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // accepted pixels feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            smooth_pixel(s_axis_tdata);
            pixels_taken++;
        end
    end

    // accepted results against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (smoothed_q.size() == 0) begin
                $error("unexpected result: pixel_out %0d row %0d col %0d",
                       m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W +: OUT_POS_W],
                       m_axis_tdata[PIX_W+OUT_POS_W +: OUT_POS_W]);
                fail_count++;
            end else begin
                want = smoothed_q.pop_front();
                if (m_axis_tdata[PIX_W-1:0] !== want.pix) begin
                    $error("pixel_out: expected %0d, got %0d", want.pix,
                           m_axis_tdata[PIX_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[PIX_W +: OUT_POS_W] !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row,
                           m_axis_tdata[PIX_W +: OUT_POS_W]);
                    fail_count++;
                end
                if (m_axis_tdata[PIX_W+OUT_POS_W +: OUT_POS_W] !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col,
                           m_axis_tdata[PIX_W+OUT_POS_W +: OUT_POS_W]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic set_flow(input t_flow flow);
        case (flow)
            FLOW_FREE:      begin idle_pct = 0;  stall_pct = 0;  end
            FLOW_SRC_IDLE:  begin idle_pct = 60; stall_pct = 0;  end
            FLOW_SNK_STALL: begin idle_pct = 0;  stall_pct = 60; end
            default:        begin idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // all pixels taken, all results seen, then a pause for pixels still in the pipe
    task automatic wait_idle();
        do @(posedge i_clk);
        while (!(pixels_taken == pixels_queued && smoothed_q.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
            if (idx == REG_FRAME_WIDTH) cfg_width = CFG_W'(val);
            else cfg_height = CFG_W'(val);
            cur_row = 0;
            cur_col = 0;
        end
    endtask

    task automatic queue_pixels(input int n, input t_pattern pat, input int w);
        t_pix p;
        for (int i = 0; i < n; i++) begin
            case (pat)
                PAT_FLAT_HIGH: p = 8'hFF;
                PAT_FLAT_LOW:  p = 8'h00;
                PAT_CHECKER:   p = (((i % w) ^ (i / w)) & 1) ? 8'hFF : 8'h00;
                PAT_GRADIENT:  p = PIX_W'(i * 13 + (i / w) * 7);
                PAT_EXTREME:   p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:       p = PIX_W'($urandom_range(0, 255));
            endcase
            pixel_queue.push_back(p);
            pixels_queued++;
        end
    endtask

    task automatic start_phase(input int w, input int h, input int n, input t_pattern pat,
                               input t_flow flow);
        wait_idle();
        set_flow(flow);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        queue_pixels(n, pat, clamp_size(w, MAX_WIDTH_DEF));
    endtask

    initial begin
        int       w, h, n, area, rand_items, phase_idx;
        t_pattern pat;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sizes from reset, a few pixels of the first row
        set_flow(FLOW_BOTH);
        queue_pixels(12, PAT_RANDOM, RESET_WIDTH);

        // sizes below the minimum clamp to 8, one whole frame at full scale
        start_phase(0, 3, 64, PAT_FLAT_HIGH, FLOW_SNK_STALL);

        // long receiver hold-off while the sender keeps going
        wait_idle();
        set_flow(FLOW_FREE);
        write_reg(REG_FRAME_WIDTH, 9);
        write_reg(REG_FRAME_HEIGHT, 9);
        hold_asked++;
        queue_pixels(70, PAT_CHECKER, 9);

        // writes to unused indexes leave the frame position alone
        wait_idle();
        set_flow(FLOW_SRC_IDLE);
        write_reg(REG_SPARE_A, 2047);
        write_reg(REG_SPARE_B, 0);
        queue_pixels(11, PAT_GRADIENT, 9);

        start_phase(12, 2047, 84, PAT_GRADIENT, FLOW_BOTH);
        start_phase(1500, 8, 16, PAT_RANDOM, FLOW_FREE);

        rand_items = 0;
        phase_idx  = 0;
        forever begin
            wait_idle();
            if (rand_items >= RANDOM_ITEMS)
                break;
            w    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 10);
            h    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 10);
            area = clamp_size(w, MAX_WIDTH_DEF) * clamp_size(h, MAX_HEIGHT);
            n    = $urandom_range(area / 2, area);
            case ($urandom_range(0, 9))
                6:       pat = PAT_GRADIENT;
                7:       pat = PAT_EXTREME;
                8:       pat = PAT_CHECKER;
                default: pat = PAT_RANDOM;
            endcase
            start_phase(w, h, n, pat, t_flow'(phase_idx % 4));
            rand_items += n;
            phase_idx++;
        end

        if (fail_count == 0 && smoothed_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gs7_pkg.sv
rtl/gs7_hwin.sv
rtl/gs7_vstore.sv
rtl/gs7_burst.sv
rtl/gaussian_7x7_fixed_smoother.sv
dv/tb_gaussian_7x7_fixed_smoother.sv
